// ===== src/rcim_pkg.sv =====
// ----------------------------------------------------------------------------
// rcim_pkg
// Shared constants, codes and types of the receiver input monitor.
// ----------------------------------------------------------------------------
package rcim_pkg;

	localparam int CHANNEL_BITS_DEFAULT  = 12;
	localparam int SEQUENCE_BITS_DEFAULT = 8;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int MID_W       = 12;
	localparam int LONG_W      = 12;
	localparam int LOSS_W      = 16;
	localparam int PRESS_W     = 12;
	localparam int FRAMES_W    = 5;
	localparam int SWITCH_W    = 4;
	localparam int LED_W       = 2;
	localparam int BUTTON_W    = 2;
	localparam int REQ_W       = 2;

	localparam logic [MID_W-1:0]    MID_STICK_RESET   = MID_W'(512);
	localparam logic [LONG_W-1:0]   LONG_PRESS_RESET  = LONG_W'(150);
	localparam logic [LOSS_W-1:0]   PANIC_LIMIT_RESET = LOSS_W'(500);
	localparam logic [LOSS_W-1:0]   LOSS_RESET        = LOSS_W'(1000);
	localparam logic [LOSS_W-1:0]   LOSS_STEP         = LOSS_W'(10);
	localparam logic [FRAMES_W-1:0] TRIM_FRAMES       = FRAMES_W'(25);
	localparam logic [PRESS_W-1:0]  PRESS_CAP         = PRESS_W'(4000);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MID_STICK   = 2'd0,
		REG_LONG_PRESS  = 2'd1,
		REG_PANIC_LIMIT = 2'd2
	} reg_index_t;

	typedef enum logic [BUTTON_W-1:0] {
		BTN_TOGGLE = 2'd0,
		BTN_HOLD   = 2'd1,
		BTN_HOME   = 2'd2
	} button_mode_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_HOLD   = 2'd0,
		REQ_RESUME = 2'd1,
		REQ_IDLE   = 2'd2,
		REQ_HOME   = 2'd3
	} request_code_t;

	typedef enum logic [LED_W-1:0] {
		LED_OFF   = 2'd0,
		LED_FLASH = 2'd2
	} led_mode_t;

endpackage

// ===== src/rcim_if.sv =====
// ----------------------------------------------------------------------------
// rcim_if
// Valid/ready channels for receiver ticks and monitor results.
// ----------------------------------------------------------------------------
interface rcim_in_if #(
	parameter int CHANNEL_BITS = 12
);
	logic                    valid;
	logic                    ready;
	logic                    frame_valid;
	logic [CHANNEL_BITS-1:0] throttle_channel;
	logic [CHANNEL_BITS-1:0] roll_channel;
	logic [CHANNEL_BITS-1:0] pitch_channel;
	logic [CHANNEL_BITS-1:0] yaw_channel;
	logic [CHANNEL_BITS-1:0] aux_channel;
	logic [CHANNEL_BITS-1:0] flap_channel;
	logic                    is_armed;
	logic                    auto_mode;

	modport source (
		output valid, frame_valid, throttle_channel, roll_channel, pitch_channel,
		       yaw_channel, aux_channel, flap_channel, is_armed, auto_mode,
		input  ready
	);
	modport sink (
		input  valid, frame_valid, throttle_channel, roll_channel, pitch_channel,
		       yaw_channel, aux_channel, flap_channel, is_armed, auto_mode,
		output ready
	);
endinterface

interface rcim_out_if #(
	parameter int CHANNEL_BITS  = 12,
	parameter int SEQUENCE_BITS = 8
);
	logic                     valid;
	logic                     ready;
	logic [CHANNEL_BITS-1:0]  throttle_trim;
	logic [CHANNEL_BITS-1:0]  yaw_trim;
	logic                     aux_on;
	logic [1:0]               button_mode;
	logic                     request_valid;
	logic [1:0]               request_code;
	logic [SEQUENCE_BITS-1:0] request_count;
	logic                     rate_switch;
	logic [3:0]               extra_switches;
	logic                     link_critical;
	logic                     motor_cut;
	logic [1:0]               led_flash;

	modport source (
		output valid, throttle_trim, yaw_trim, aux_on, button_mode, request_valid,
		       request_code, request_count, rate_switch, extra_switches,
		       link_critical, motor_cut, led_flash,
		input  ready
	);
	modport sink (
		input  valid, throttle_trim, yaw_trim, aux_on, button_mode, request_valid,
		       request_code, request_count, rate_switch, extra_switches,
		       link_critical, motor_cut, led_flash,
		output ready
	);
endinterface

// ===== src/rc_receiver_input_monitor_top.sv =====
// ----------------------------------------------------------------------------
// rc_receiver_input_monitor_top
// Per-tick receiver link monitor: link-loss counter, trims, switches, button.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  in        in   valid/ready        one control tick of receiver channels
//  out       out  valid/ready        monitor flags and requests for that tick
//  config    in   write_enable only  reg_index, write_data
//
// One word is taken per cycle unless a stalled result blocks the input; its
// result is in the output register in the next cycle. The state update and the
// output register are one stage. A stalled result holds the output register and
// blocks the input only while it is full and not taken. Reset loads a high loss count: the link counts as lost.
module rc_receiver_input_monitor_top #(
	parameter int CHANNEL_BITS  = rcim_pkg::CHANNEL_BITS_DEFAULT,
	parameter int SEQUENCE_BITS = rcim_pkg::SEQUENCE_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rcim_in_if.sink                             in,
	rcim_out_if.source                          out,
	input  logic                                write_enable,
	input  logic [rcim_pkg::CFG_INDEX_W-1:0]    reg_index,
	input  logic [rcim_pkg::CFG_DATA_W-1:0]     write_data
);
	import rcim_pkg::*;

	localparam int CMP_W = (CHANNEL_BITS > MID_W) ? CHANNEL_BITS : MID_W;

	logic [MID_W-1:0]         mid_stick_q;
	logic [LONG_W-1:0]        long_press_q;
	logic [LOSS_W-1:0]        panic_limit_q;

	logic [LOSS_W-1:0]        loss_q;
	logic [FRAMES_W-1:0]      frames_q;
	logic [CHANNEL_BITS-1:0]  thr_trim_q;
	logic [CHANNEL_BITS-1:0]  yaw_trim_q;
	logic                     aux_q;
	logic [PRESS_W-1:0]       press_q;
	button_mode_t             button_q;
	logic [SEQUENCE_BITS-1:0] seq_q;
	logic                     rate_q;
	logic [SWITCH_W-1:0]      switch_q;
	logic                     critical_q;
	led_mode_t                led_q;

	logic                     res_valid_q;
	logic                     res_req_valid_q;
	request_code_t            res_req_code_q;
	logic                     res_cut_q;

	logic [LOSS_W-1:0]        loss_d;
	logic [FRAMES_W-1:0]      frames_d;
	logic [CHANNEL_BITS-1:0]  thr_trim_d;
	logic [CHANNEL_BITS-1:0]  yaw_trim_d;
	logic                     aux_d;
	logic [PRESS_W-1:0]       press_d;
	button_mode_t             button_d;
	logic [SEQUENCE_BITS-1:0] seq_d;
	logic                     rate_d;
	logic [SWITCH_W-1:0]      switch_d;
	logic                     critical_d;
	led_mode_t                led_d;
	logic                     req_valid_d;
	request_code_t            req_code_d;
	logic                     cut_d;

	logic                     in_acc;
	logic [CMP_W-1:0]         mid_ext;
	logic [CMP_W-1:0]         aux_ext;
	logic [CMP_W-1:0]         flap_ext;
	logic [LOSS_W:0]          loss_inc;

	assign in_acc   = in.valid && in.ready;
	assign in.ready = !res_valid_q || out.ready;
	assign mid_ext  = CMP_W'(mid_stick_q);
	assign aux_ext  = CMP_W'(in.aux_channel);
	assign flap_ext = CMP_W'(in.flap_channel);
	assign loss_inc = {1'b0, loss_q} + (LOSS_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_stick_q   <= MID_STICK_RESET;
			long_press_q  <= LONG_PRESS_RESET;
			panic_limit_q <= PANIC_LIMIT_RESET;
		end else if (write_enable) begin
			unique case (reg_index_t'(reg_index))
				REG_MID_STICK:   mid_stick_q   <= write_data[MID_W-1:0];
				REG_LONG_PRESS:  long_press_q  <= write_data[LONG_W-1:0];
				REG_PANIC_LIMIT: panic_limit_q <= write_data[LOSS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		loss_d      = loss_q;
		frames_d    = frames_q;
		thr_trim_d  = thr_trim_q;
		yaw_trim_d  = yaw_trim_q;
		aux_d       = aux_q;
		press_d     = press_q;
		button_d    = button_q;
		seq_d       = seq_q;
		rate_d      = rate_q;
		switch_d    = switch_q;
		critical_d  = critical_q;
		led_d       = led_q;
		req_valid_d = 1'b0;
		req_code_d  = REQ_HOLD;
		cut_d       = 1'b0;
		if (in.frame_valid) begin
			if (loss_q > LOSS_STEP) begin
				loss_d = loss_q - LOSS_STEP;
				if (in.is_armed) begin
					critical_d = 1'b0;
				end
			end
			if (frames_q < TRIM_FRAMES) begin
				thr_trim_d = in.throttle_channel;
				yaw_trim_d = in.yaw_channel;
				frames_d   = frames_q + FRAMES_W'(1);
			end
			aux_d = !(aux_ext > mid_ext);
			if (flap_ext > mid_ext) begin
				press_d = (press_q >= PRESS_CAP) ? PRESS_CAP : press_q + PRESS_W'(1);
			end
			if (flap_ext < mid_ext && press_q != '0) begin
				if (press_q <= long_press_q) begin
					if (button_q == BTN_TOGGLE || button_q == BTN_HOME) begin
						button_d   = BTN_HOLD;
						req_code_d = REQ_HOLD;
					end else begin
						button_d   = BTN_TOGGLE;
						req_code_d = in.auto_mode ? REQ_RESUME : REQ_IDLE;
					end
				end else begin
					button_d   = BTN_HOME;
					req_code_d = REQ_HOME;
				end
				press_d     = '0;
				req_valid_d = 1'b1;
				seq_d       = seq_q + SEQUENCE_BITS'(1);
			end
			if (in.aux_channel[3:0] == 4'd0 && in.flap_channel[3:0] == 4'd0) begin
				rate_d   = in.aux_channel[4];
				switch_d = in.flap_channel[7:4];
			end
			led_d = LED_OFF;
		end else begin
			if (loss_inc > {1'b0, panic_limit_q}) begin
				loss_d = panic_limit_q;
				if (in.is_armed) begin
					cut_d      = 1'b1;
					critical_d = 1'b1;
				end
				led_d = LED_FLASH;
			end else begin
				loss_d = loss_inc[LOSS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_q      <= LOSS_RESET;
			frames_q    <= '0;
			thr_trim_q  <= '0;
			yaw_trim_q  <= '0;
			aux_q       <= 1'b0;
			press_q     <= '0;
			button_q    <= BTN_TOGGLE;
			seq_q       <= '0;
			rate_q      <= 1'b0;
			switch_q    <= '0;
			critical_q  <= 1'b0;
			led_q       <= LED_OFF;
		end else if (in_acc) begin
			loss_q      <= loss_d;
			frames_q    <= frames_d;
			thr_trim_q  <= thr_trim_d;
			yaw_trim_q  <= yaw_trim_d;
			aux_q       <= aux_d;
			press_q     <= press_d;
			button_q    <= button_d;
			seq_q       <= seq_d;
			rate_q      <= rate_d;
			switch_q    <= switch_d;
			critical_q  <= critical_d;
			led_q       <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in.ready) begin
			res_valid_q <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_req_valid_q <= req_valid_d;
			res_req_code_q  <= req_code_d;
			res_cut_q       <= cut_d;
		end
	end

	assign out.valid          = res_valid_q;
	assign out.throttle_trim  = thr_trim_q;
	assign out.yaw_trim       = yaw_trim_q;
	assign out.aux_on         = aux_q;
	assign out.button_mode    = button_q;
	assign out.request_valid  = res_req_valid_q;
	assign out.request_code   = res_req_code_q;
	assign out.request_count  = seq_q;
	assign out.rate_switch    = rate_q;
	assign out.extra_switches = switch_q;
	assign out.link_critical  = critical_q;
	assign out.motor_cut      = res_cut_q;
	assign out.led_flash      = led_q;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> res_valid_q)
		else $error("accepted word produced no result");

	a_cut_is_critical: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_cut_q) |-> (critical_q && led_q == LED_FLASH))
		else $error("motor cut without critical flag and flashing LED");

	a_missing_no_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !in.frame_valid) |=> !res_req_valid_q)
		else $error("request issued on a missing frame");

	a_press_capped: assert property (@(posedge clk) disable iff (!arst_n)
		press_q <= PRESS_CAP)
		else $error("press counter beyond cap");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the receiver input monitor. Directed tests cover the link-loss
// counter, panic and recovery, trims, switch decoding and the flap button;
// random traffic then runs under several register settings. Every result word
// is checked field by field against a predictor kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import rcim_pkg::*;

	localparam int CH_W           = CHANNEL_BITS_DEFAULT;
	localparam int SEQ_W          = SEQUENCE_BITS_DEFAULT;
	localparam int CH_MAX         = (1 << CH_W) - 1;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int PRINT_LIMIT    = 50;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic            frame_valid;
		logic [CH_W-1:0] throttle_channel;
		logic [CH_W-1:0] roll_channel;
		logic [CH_W-1:0] pitch_channel;
		logic [CH_W-1:0] yaw_channel;
		logic [CH_W-1:0] aux_channel;
		logic [CH_W-1:0] flap_channel;
		logic            is_armed;
		logic            auto_mode;
	} tick_t;

	typedef struct {
		logic [CH_W-1:0]  throttle_trim;
		logic [CH_W-1:0]  yaw_trim;
		logic             aux_on;
		button_mode_t     button_mode;
		logic             request_valid;
		request_code_t    request_code;
		logic [SEQ_W-1:0] request_count;
		logic             rate_switch;
		logic [3:0]       extra_switches;
		logic             link_critical;
		logic             motor_cut;
		led_mode_t        led_flash;
	} flags_t;

	logic                   clk;
	logic                   arst_n;
	logic                   write_enable;
	logic [CFG_INDEX_W-1:0] reg_index;
	logic [CFG_DATA_W-1:0]  write_data;

	rcim_in_if  #(.CHANNEL_BITS(CH_W)) in_ch ();
	rcim_out_if #(.CHANNEL_BITS(CH_W), .SEQUENCE_BITS(SEQ_W)) out_ch ();

	rc_receiver_input_monitor_top #(
		.CHANNEL_BITS (CH_W),
		.SEQUENCE_BITS(SEQ_W)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in          (in_ch),
		.out         (out_ch),
		.write_enable(write_enable),
		.reg_index   (reg_index),
		.write_data  (write_data)
	);

	logic [MID_W-1:0]    mid_stick        = MID_STICK_RESET;
	logic [LONG_W-1:0]   long_press_ticks = LONG_PRESS_RESET;
	logic [LOSS_W-1:0]   panic_limit      = PANIC_LIMIT_RESET;

	int unsigned         loss_count  = LOSS_RESET;
	logic [FRAMES_W-1:0] frames_seen = '0;
	logic [CH_W-1:0]     throttle_trim_q = '0;
	logic [CH_W-1:0]     yaw_trim_q  = '0;
	logic                aux_on_q    = 1'b0;
	logic [PRESS_W-1:0]  press_ticks = '0;
	button_mode_t        button_q    = BTN_TOGGLE;
	logic [SEQ_W-1:0]    request_seq = '0;
	logic                rate_q      = 1'b0;
	logic [3:0]          switches_q  = '0;
	logic                critical_q  = 1'b0;
	led_mode_t           led_q       = LED_OFF;

	flags_t flags_due[$];
	int     mismatches   = 0;
	int     quiet_cycles = 0;
	bit     src_calm     = 1'b0;
	bit     sink_calm    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic flags_t advance_monitor(input tick_t t);
		flags_t r;
		r.request_valid = 1'b0;
		r.request_code  = REQ_HOLD;
		r.motor_cut     = 1'b0;
		if (t.frame_valid) begin
			if (loss_count > LOSS_STEP) begin
				loss_count = loss_count - LOSS_STEP;
				if (t.is_armed && critical_q)
					critical_q = 1'b0;
			end
			if (frames_seen < TRIM_FRAMES) begin
				throttle_trim_q = t.throttle_channel;
				yaw_trim_q      = t.yaw_channel;
				frames_seen     = frames_seen + 1'b1;
			end
			aux_on_q = (t.aux_channel <= mid_stick);
			if (t.flap_channel > mid_stick && press_ticks < PRESS_CAP)
				press_ticks = press_ticks + 1'b1;
			if (t.flap_channel < mid_stick && press_ticks != 0) begin
				if (press_ticks <= long_press_ticks) begin
					if (button_q == BTN_TOGGLE || button_q == BTN_HOME) begin
						button_q       = BTN_HOLD;
						r.request_code = REQ_HOLD;
					end else begin
						button_q       = BTN_TOGGLE;
						r.request_code = t.auto_mode ? REQ_RESUME : REQ_IDLE;
					end
				end else begin
					button_q       = BTN_HOME;
					r.request_code = REQ_HOME;
				end
				press_ticks     = '0;
				r.request_valid = 1'b1;
				request_seq     = request_seq + 1'b1;
			end
			if (t.aux_channel[3:0] == 4'd0 && t.flap_channel[3:0] == 4'd0) begin
				rate_q     = t.aux_channel[4];
				switches_q = t.flap_channel[7:4];
			end
			led_q = LED_OFF;
		end else if (loss_count + 1 > panic_limit) begin
			loss_count = panic_limit;
			if (t.is_armed) begin
				r.motor_cut = 1'b1;
				critical_q  = 1'b1;
			end
			led_q = LED_FLASH;
		end else begin
			loss_count = loss_count + 1;
		end
		r.throttle_trim  = throttle_trim_q;
		r.yaw_trim       = yaw_trim_q;
		r.aux_on         = aux_on_q;
		r.button_mode    = button_q;
		r.request_count  = request_seq;
		r.rate_switch    = rate_q;
		r.extra_switches = switches_q;
		r.link_critical  = critical_q;
		r.led_flash      = led_q;
		return r;
	endfunction

	function automatic int pick_delay(input bit calm);
		if (calm)
			return 0;
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
	endfunction

	// Level 0 is at or below the threshold, 1 mostly above it, anything else equal to it.
	function automatic logic [CH_W-1:0] flap_level(input int level);
		int              m;
		logic [CH_W-1:0] v;
		m = mid_stick;
		if (level == 0)
			v = (m == 0) ? '0 : CH_W'($urandom_range(0, m - 1));
		else if (level == 1)
			v = (m == CH_MAX) ? CH_W'(CH_MAX) : CH_W'($urandom_range(m + 1, CH_MAX));
		else
			v = CH_W'(m);
		if (level < 2 && $urandom_range(0, 2) == 0)
			v[3:0] = 4'd0;
		return v;
	endfunction

	function automatic tick_t noise_tick();
		tick_t t;
		t.frame_valid      = ($urandom_range(0, 4) != 0);
		t.throttle_channel = CH_W'($urandom);
		t.roll_channel     = CH_W'($urandom);
		t.pitch_channel    = CH_W'($urandom);
		t.yaw_channel      = CH_W'($urandom);
		t.aux_channel      = CH_W'($urandom);
		if ($urandom_range(0, 1) == 0)
			t.aux_channel[3:0] = 4'd0;
		t.flap_channel = ($urandom_range(0, 1) == 0) ? CH_W'($urandom)
			: flap_level($urandom_range(0, 2));
		t.is_armed  = 1'($urandom_range(0, 1));
		t.auto_mode = 1'($urandom_range(0, 1));
		return t;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns: %s", $time, what);
	endtask

	task automatic compare_field(input string field, input logic [31:0] seen,
			input logic [31:0] wanted);
		if (seen !== wanted)
			report_mismatch($sformatf("%s is %0d, expected %0d", field, seen, wanted));
	endtask

	task automatic send_tick(input tick_t t);
		int gap;
		gap = pick_delay(src_calm);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid            <= 1'b1;
		in_ch.frame_valid      <= t.frame_valid;
		in_ch.throttle_channel <= t.throttle_channel;
		in_ch.roll_channel     <= t.roll_channel;
		in_ch.pitch_channel    <= t.pitch_channel;
		in_ch.yaw_channel      <= t.yaw_channel;
		in_ch.aux_channel      <= t.aux_channel;
		in_ch.flap_channel     <= t.flap_channel;
		in_ch.is_armed         <= t.is_armed;
		in_ch.auto_mode        <= t.auto_mode;
		do @(posedge clk); while (!in_ch.ready);
		flags_due.push_back(advance_monitor(t));
	endtask

	task automatic send_directed(input bit frame_ok, input bit armed, input bit auto_on,
			input logic [CH_W-1:0] thr, input logic [CH_W-1:0] yaw,
			input logic [CH_W-1:0] aux, input logic [CH_W-1:0] flap);
		tick_t t;
		t = noise_tick();
		t.frame_valid      = frame_ok;
		t.is_armed         = armed;
		t.auto_mode        = auto_on;
		t.throttle_channel = thr;
		t.yaw_channel      = yaw;
		t.aux_channel      = aux;
		t.flap_channel     = flap;
		send_tick(t);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (flags_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		drain_results();
		write_enable <= 1'b1;
		reg_index    <= idx;
		write_data   <= value;
		@(posedge clk);
		write_enable <= 1'b0;
		case (idx)
			REG_MID_STICK:   mid_stick        = value[MID_W-1:0];
			REG_LONG_PRESS:  long_press_ticks = value[LONG_W-1:0];
			REG_PANIC_LIMIT: panic_limit      = value[LOSS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int mid, input int long_press, input int panic);
		write_register(REG_MID_STICK, CFG_DATA_W'(mid));
		write_register(REG_LONG_PRESS, CFG_DATA_W'(long_press));
		write_register(REG_PANIC_LIMIT, CFG_DATA_W'(panic));
	endtask

	task automatic check_word();
		flags_t e;
		if (flags_due.size() == 0) begin
			report_mismatch("result word with nothing expected");
			return;
		end
		e = flags_due.pop_front();
		compare_field("throttle_trim", 32'(out_ch.throttle_trim), 32'(e.throttle_trim));
		compare_field("yaw_trim", 32'(out_ch.yaw_trim), 32'(e.yaw_trim));
		compare_field("aux_on", 32'(out_ch.aux_on), 32'(e.aux_on));
		compare_field("button_mode", 32'(out_ch.button_mode), 32'(e.button_mode));
		compare_field("request_valid", 32'(out_ch.request_valid), 32'(e.request_valid));
		compare_field("request_code", 32'(out_ch.request_code), 32'(e.request_code));
		compare_field("request_count", 32'(out_ch.request_count), 32'(e.request_count));
		compare_field("rate_switch", 32'(out_ch.rate_switch), 32'(e.rate_switch));
		compare_field("extra_switches", 32'(out_ch.extra_switches), 32'(e.extra_switches));
		compare_field("link_critical", 32'(out_ch.link_critical), 32'(e.link_critical));
		compare_field("motor_cut", 32'(out_ch.motor_cut), 32'(e.motor_cut));
		compare_field("led_flash", 32'(out_ch.led_flash), 32'(e.led_flash));
	endtask

	initial begin : result_sink
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_delay(sink_calm);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			check_word();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// The link counts as lost after reset, so the first missing frame panics.
	task automatic test_link_loss();
		send_directed(1'b0, 1'b1, 1'b0, 12'd100, 12'd200, 12'd300, 12'd512);
		send_directed(1'b0, 1'b0, 1'b0, 12'd101, 12'd201, 12'd301, 12'd512);
		send_directed(1'b1, 1'b0, 1'b0, 12'd102, 12'd202, 12'd302, 12'd512);
		send_directed(1'b1, 1'b1, 1'b1, 12'd103, 12'd203, 12'd303, 12'd512);
	endtask

	task automatic test_channel_extremes();
		send_directed(1'b1, 1'b1, 1'b0, 12'hFFF, 12'h000, 12'hFFF, 12'h000);
		send_directed(1'b1, 1'b0, 1'b1, 12'h000, 12'hFFF, 12'h000, 12'hFFF);
		send_directed(1'b1, 1'b1, 1'b1, 12'h555, 12'hAAA, 12'h010, 12'h0F0);
		send_directed(1'b1, 1'b0, 1'b0, 12'hAAA, 12'h555, 12'h012, 12'h200);
		send_directed(1'b1, 1'b1, 1'b0, 12'h7FF, 12'h800, 12'h000, 12'h200);
	endtask

	task automatic test_button_requests();
		send_directed(1'b1, 1'b1, 1'b1, 12'd0, 12'd0, 12'd900, 12'd600);
		send_directed(1'b0, 1'b1, 1'b1, 12'd0, 12'd0, 12'd900, 12'd100);
		send_directed(1'b1, 1'b1, 1'b1, 12'd0, 12'd0, 12'd900, 12'd100);
		send_directed(1'b1, 1'b1, 1'b0, 12'd0, 12'd0, 12'd100, 12'd700);
		send_directed(1'b1, 1'b1, 1'b0, 12'd0, 12'd0, 12'd100, 12'd300);
		send_directed(1'b1, 1'b0, 1'b1, 12'd0, 12'd0, 12'd512, 12'd513);
		send_directed(1'b1, 1'b0, 1'b1, 12'd0, 12'd0, 12'd512, 12'd511);
	endtask

	task automatic test_register_extremes();
		write_register(REG_LONG_PRESS, CFG_DATA_W'(0));
		send_directed(1'b1, 1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd800);
		send_directed(1'b1, 1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd10);
		write_register(REG_UNUSED, 16'hFFFF);
		write_register(REG_LONG_PRESS, CFG_DATA_W'(1));
		send_directed(1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd800);
		send_directed(1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd800);
		send_directed(1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd10);
		send_directed(1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd800);
		send_directed(1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd10);
		write_register(REG_PANIC_LIMIT, CFG_DATA_W'(11));
		write_register(REG_MID_STICK, CFG_DATA_W'(CH_MAX));
		send_directed(1'b0, 1'b1, 1'b0, 12'd0, 12'd0, 12'hFFF, 12'hFFF);
		send_directed(1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'hFFF, 12'hFFF);
		send_directed(1'b1, 1'b1, 1'b0, 12'd0, 12'd0, 12'hFFE, 12'hFFE);
		send_directed(1'b0, 1'b0, 1'b0, 12'd0, 12'd0, 12'hFFE, 12'hFFE);
	endtask

	task automatic run_random(input int count);
		int    sent;
		int    kind;
		int    n;
		int    hold_max;
		bit    armed;
		tick_t t;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				hold_max = (long_press_ticks > 22) ? 24 : long_press_ticks + 2;
				n = $urandom_range(1, hold_max);
				repeat (n) begin
					t = noise_tick();
					t.frame_valid  = ($urandom_range(0, 7) != 0);
					t.flap_channel = ($urandom_range(0, 7) == 0) ? flap_level(2) : flap_level(1);
					send_tick(t);
					sent++;
				end
				t = noise_tick();
				t.frame_valid  = 1'b1;
				t.flap_channel = flap_level(0);
				send_tick(t);
				sent++;
			end else if (kind == 4) begin
				n = $urandom_range(2, 20);
				repeat (n) begin
					t = noise_tick();
					t.frame_valid  = 1'b1;
					t.flap_channel = flap_level(sent % 2);
					send_tick(t);
					sent++;
				end
			end else if (kind < 7) begin
				armed = 1'($urandom_range(0, 1));
				n = $urandom_range(1, 30);
				repeat (n) begin
					t = noise_tick();
					t.frame_valid = 1'b0;
					t.is_armed    = armed;
					send_tick(t);
					sent++;
				end
				n = $urandom_range(1, 6);
				repeat (n) begin
					t = noise_tick();
					t.frame_valid = 1'b1;
					send_tick(t);
					sent++;
				end
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					send_tick(noise_tick());
					sent++;
				end
			end
		end
	endtask

	task automatic test_random_traffic();
		sink_calm = 1'b1;
		configure(512, 5, 30);
		run_random(100);
		sink_calm = 1'b0;
		configure(0, 0, 11);
		run_random(60);
		configure(CH_MAX, CH_MAX, 65535);
		run_random(60);
		repeat (2) begin
			configure($urandom_range(16, 4000), $urandom_range(1, 12), $urandom_range(11, 60));
			run_random(90);
		end
		src_calm  = 1'b1;
		sink_calm = 1'b1;
		configure(2048, 3, 25);
		run_random(110);
		src_calm  = 1'b0;
		sink_calm = 1'b0;
		configure(MID_STICK_RESET, LONG_PRESS_RESET, PANIC_LIMIT_RESET);
		run_random(70);
	endtask

	initial begin
		arst_n                 = 1'b0;
		write_enable           = 1'b0;
		reg_index              = '0;
		write_data             = '0;
		in_ch.valid            = 1'b0;
		in_ch.frame_valid      = 1'b0;
		in_ch.throttle_channel = '0;
		in_ch.roll_channel     = '0;
		in_ch.pitch_channel    = '0;
		in_ch.yaw_channel      = '0;
		in_ch.aux_channel      = '0;
		in_ch.flap_channel     = '0;
		in_ch.is_armed         = 1'b0;
		in_ch.auto_mode        = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_link_loss();
		test_channel_extremes();
		test_button_requests();
		test_register_extremes();
		test_random_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
src/rcim_pkg.sv
src/rcim_if.sv
src/rc_receiver_input_monitor_top.sv
verif/tb.sv
